// ===== rtl/core/pcr_pkg.sv =====
// Shared types and constants for the pointer chain relocator.
package pcr_pkg;

	localparam int ADDR_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int PADDR_W         = 3;
	localparam int NEXT_W          = 30;

	// Input command codes
	localparam logic [1:0] CMD_HEADER = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_NODE   = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_WIDTH  = 2'd1;
	localparam logic [1:0] ERR_OFFSET = 2'd2;

	// Register select (paddr bit 2)
	localparam int         REG_SEL_BIT = 2;
	localparam logic       REG_BASE    = 1'b0;
	localparam logic       REG_TABLE   = 1'b1;

	localparam logic [31:0] WIDTH_ERR_MIN  = 32'd20;
	localparam logic [31:0] WIDTH_CLAMP    = 32'd30;
	localparam logic [4:0]  NEXT_WIDTH_MAX = 5'd30;
	localparam logic [4:0]  FIELD_TOTAL    = 5'd31;
	localparam logic [31:0] OFFSET_LIMIT   = 32'h0500_0000;
	localparam logic [23:0] ENTRIES_MAX    = 24'hFF_FFFF;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_HEADER = 2'd1,
		OP_START  = 2'd2,
		OP_NODE   = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [1:0]        error;
		logic              table_done;
		logic [31:0]       addr;
		logic [31:0]       offset;
		logic [NEXT_W-1:0] next;
	} pcr_op_t;

endpackage

// ===== rtl/core/pcr_front.sv =====
// Front end: accept input words, track header and table count, decode node words.
module pcr_front
	import pcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] word,
	input  logic [31:0] base_address,
	input  logic [23:0] table_entries,
	input  logic        queue_full,
	output logic        push,
	output pcr_op_t     op
);

	logic [4:0]  next_width_q;
	logic [23:0] entries_seen_q;
	logic [23:0] entries_inc;
	logic [4:0]  k;
	logic [4:0]  k_msb;
	logic [31:0] fmask;
	logic [30:0] next_raw;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	assign entries_inc = (entries_seen_q != ENTRIES_MAX) ? entries_seen_q + 24'd1
	                                                     : entries_seen_q;
	assign k        = FIELD_TOTAL - next_width_q;
	assign k_msb    = k - 5'd1;
	assign fmask    = (32'd1 << k) - 32'd1;
	assign next_raw = word[30:0] >> k;

	always_comb begin
		op            = '0;
		op.kind       = OP_NONE;
		op.error      = ERR_NONE;
		unique case (cmd)
			CMD_HEADER: begin
				op.kind = OP_HEADER;
				if (word >= WIDTH_ERR_MIN) begin
					op.error = ERR_WIDTH;
				end
			end
			CMD_START: begin
				op.kind       = OP_START;
				op.addr       = base_address + word;
				op.table_done = (entries_inc == table_entries);
				if (word >= OFFSET_LIMIT) begin
					op.error = ERR_OFFSET;
				end
			end
			CMD_NODE: begin
				op.kind = OP_NODE;
				if (!word[31]) begin
					op.offset = (word & fmask) | (word[k_msb] ? ~fmask : 32'd0);
					op.next   = next_raw[NEXT_W-1:0];
				end else begin
					// bit 30 picks full negative word or the low 31 bits
					op.offset = word[30] ? word : {1'b0, word[30:0]};
				end
			end
			default: begin
				op.kind = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_width_q   <= '0;
			entries_seen_q <= '0;
		end else if (push) begin
			if (cmd == CMD_HEADER) begin
				next_width_q   <= (word > WIDTH_CLAMP) ? NEXT_WIDTH_MAX : word[4:0];
				entries_seen_q <= 24'd1;
			end else if (cmd == CMD_START) begin
				entries_seen_q <= entries_inc;
			end
		end
	end

endmodule

// ===== rtl/core/pcr_queue.sv =====
// Small FIFO of decoded operations between front and back.
module pcr_queue
	import pcr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pcr_op_t din,
	input  logic    pop,
	output pcr_op_t dout,
	output logic    full,
	output logic    empty
);

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	pcr_op_t         mem_q [DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH)) else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

endmodule

// ===== rtl/core/pcr_back.sv =====
// Back end: walk the chain address, form the write-back and next read, hold the result.
module pcr_back
	import pcr_pkg::*;
#(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pcr_op_t     op,
	input  logic        op_valid,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_enable,
	output logic [31:0] write_address,
	output logic [31:0] write_data,
	output logic        read_enable,
	output logic [31:0] read_address,
	output logic        chain_done,
	output logic        table_done,
	output logic [1:0]  error
);

	localparam int NaW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

	logic [NaW-1:0] node_q;
	logic [31:0]    node_ext;
	logic [NaW-1:0] node_nxt;
	logic [NaW-1:0] start_addr;
	logic           has_next;
	logic           load;

	logic        out_valid_q;
	logic        write_enable_q;
	logic [31:0] write_address_q;
	logic [31:0] write_data_q;
	logic        read_enable_q;
	logic [31:0] read_address_q;
	logic        chain_done_q;
	logic        table_done_q;
	logic [1:0]  error_q;

	assign load       = op_valid && (!out_valid_q || out_ready);
	assign pop        = load;
	assign node_ext   = 32'(node_q);
	assign node_nxt   = NaW'(node_ext + 32'(op.next));
	assign start_addr = NaW'(op.addr);
	assign has_next   = (op.next != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			node_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && op.kind == OP_START) begin
				node_q <= start_addr;
			end else if (load && op.kind == OP_NODE && has_next) begin
				node_q <= node_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			write_enable_q  <= 1'b0;
			write_address_q <= '0;
			write_data_q    <= '0;
			read_enable_q   <= 1'b0;
			read_address_q  <= '0;
			chain_done_q    <= 1'b0;
			table_done_q    <= op.table_done;
			error_q         <= op.error;
			case (op.kind)
				OP_START: begin
					read_enable_q  <= 1'b1;
					read_address_q <= 32'(start_addr);
				end
				OP_NODE: begin
					write_enable_q  <= 1'b1;
					write_address_q <= node_ext;
					write_data_q    <= node_ext + op.offset;
					if (has_next) begin
						read_enable_q  <= 1'b1;
						read_address_q <= 32'(node_nxt);
					end else begin
						chain_done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign write_enable  = write_enable_q;
	assign write_address = write_address_q;
	assign write_data    = write_data_q;
	assign read_enable   = read_enable_q;
	assign read_address  = read_address_q;
	assign chain_done    = chain_done_q;
	assign table_done    = table_done_q;
	assign error         = error_q;

	a_done_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(chain_done_q && read_enable_q))
		else $error("chain end with a pending read");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q) else $error("loaded result not presented");

endmodule

// ===== rtl/core/pointer_chain_relocator.sv =====
// Top level of the pointer chain relocator: config registers and front/queue/back wiring.
//
// Usage:
//   Input channel (in_valid/in_ready, cmd, word) carries one word per item:
//   cmd 0 is the table header (next-field width), cmd 1 a chain start offset
//   from base_address, cmd 2 a node word returned by a memory read.
//   Output channel (out_valid/out_ready) returns exactly one result per item:
//   an optional write-back (write_enable/address/data), an optional next read
//   (read_enable/read_address), chain_done, table_done and an error code.
//   The APB port holds base_address (0x0) and table_entries (0x4); write them
//   only while the block is idle. pready is tied high.
// Timing:
//   The word enters the operation queue at its accept edge, is read straight
//   out of it and lands in the back end's result register once that register
//   is free. Throughput is one item per cycle while out_ready holds high; the
//   node-address update in the back end is a single add, so chained node
//   words may follow back to back.
// Stall:
//   When out_ready drops, the result register holds and the queue fills; the
//   input drops in_ready only once the queue is full. No result is lost.
// Reset:
//   arst_n clears the registers, header width, table count, node address and
//   the queue; the block can accept items as soon as reset is released.
module pointer_chain_relocator
	import pcr_pkg::*;
#(
	parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Input word channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [31:0]        word,
	// Result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               write_enable,
	output logic [31:0]        write_address,
	output logic [31:0]        write_data,
	output logic               read_enable,
	output logic [31:0]        read_address,
	output logic               chain_done,
	output logic               table_done,
	output logic [1:0]         error
);

	logic [31:0] base_address_q;
	logic [23:0] table_entries_q;
	logic        cfg_write;

	pcr_op_t front_op;
	pcr_op_t queue_op;
	logic    push;
	logic    pop;
	logic    queue_full;
	logic    queue_empty;

	// Register file: write on the APB access phase, read back with zero fill.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q  <= '0;
			table_entries_q <= '0;
		end else if (cfg_write) begin
			if (paddr[REG_SEL_BIT] == REG_BASE) begin
				base_address_q <= pwdata;
			end else begin
				table_entries_q <= pwdata[23:0];
			end
		end
	end

	always_comb begin
		if (paddr[REG_SEL_BIT] == REG_TABLE) begin
			prdata = 32'(table_entries_q);
		end else begin
			prdata = base_address_q;
		end
	end

	// Front end: classify each word, decode node fields, count table entries.
	pcr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.word          (word),
		.base_address  (base_address_q),
		.table_entries (table_entries_q),
		.queue_full    (queue_full),
		.push          (push),
		.op            (front_op)
	);

	// Decouple: let the front keep accepting while the result waits.
	pcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_op),
		.pop    (pop),
		.dout   (queue_op),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	// Back end: advance the chain address and drive the result register.
	pcr_back #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (queue_op),
		.op_valid      (!queue_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.read_enable   (read_enable),
		.read_address  (read_address),
		.chain_done    (chain_done),
		.table_done    (table_done),
		.error         (error)
	);

endmodule

// ===== verif/tb_pointer_chain_relocator.sv =====
// Self-checking testbench for the pointer chain relocator: random chains against a predictor.
`timescale 1ns / 100ps

module tb_pointer_chain_relocator;
	import pcr_pkg::*;

	// Register map of the configuration port: base at 0x0, table size at 0x4.
	localparam logic [PADDR_W-1:0] REG_ADDR_BASE  = 3'h0;
	localparam logic [PADDR_W-1:0] REG_ADDR_TABLE = 3'h4;
	// The fourth command code is unused; the block must answer it with an empty result.
	localparam logic [1:0]         CMD_UNUSED     = 2'd3;
	localparam int                 IDLE_PERCENT   = 14;
	localparam int                 HOLD_OFF_CYCLES = 250;
	localparam int                 WORD_TARGET    = 1400;

	// One result word, field by field, as the output ports carry it.
	typedef struct packed {
		logic        write_enable;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic        read_enable;
		logic [31:0] read_address;
		logic        chain_done;
		logic        table_done;
		logic [1:0]  error;
	} reloc_result_t;

	// Scoreboard: keeps a private copy of the registers and chain state, predicts the
	// result of every accepted word, and checks results in order against that queue.
	class reloc_scoreboard;
		logic [31:0]   base_addr;
		logic [23:0]   table_size;
		logic [4:0]    next_width;
		logic [31:0]   node_addr;
		logic [23:0]   entries_seen;
		reloc_result_t pending_results[$];
		int            failures;
		int            results_checked;
		int            chains_ended;
		int            tables_ended;
		int            flagged;

		function new();
			base_addr = '0;
			table_size = '0;
			next_width = '0;
			node_addr = '0;
			entries_seen = '0;
			failures = 0;
			results_checked = 0;
			chains_ended = 0;
			tables_ended = 0;
			flagged = 0;
		endfunction

		function void set_register(logic [PADDR_W-1:0] a, logic [31:0] d);
			if (a == REG_ADDR_TABLE)
				table_size = d[23:0];
			else
				base_addr = d;
		endfunction

		// Work out the result of one word and advance the chain state.
		function reloc_result_t relocate_word(logic [1:0] c, logic [31:0] w);
			reloc_result_t r;
			logic [31:0]   offset;
			logic [31:0]   next_field;
			logic [31:0]   fmask;
			int            k;
			r = '0;
			case (c)
				CMD_HEADER: begin
					if (w >= WIDTH_ERR_MIN)
						r.error = ERR_WIDTH;
					next_width = (w > WIDTH_CLAMP) ? NEXT_WIDTH_MAX : w[4:0];
					entries_seen = 24'd1;
				end
				CMD_START: begin
					node_addr = base_addr + w;
					if (w >= OFFSET_LIMIT)
						r.error = ERR_OFFSET;
					r.read_enable = 1'b1;
					r.read_address = node_addr;
					if (entries_seen != ENTRIES_MAX)
						entries_seen = entries_seen + 24'd1;
					r.table_done = (entries_seen == table_size);
				end
				CMD_NODE: begin
					if (!w[31]) begin
						// low k bits are a signed offset, bits 30..k the next step
						k = int'(FIELD_TOTAL) - int'(next_width);
						fmask = (32'd1 << k) - 32'd1;
						offset = w & fmask;
						if (w[k-1])
							offset = offset | ~fmask;
						next_field = {1'b0, w[30:0]} >> k;
					end else begin
						// offset-only form: bit 30 decides whether bit 31 stays
						next_field = '0;
						offset = w[30] ? w : {1'b0, w[30:0]};
					end
					r.write_enable = 1'b1;
					r.write_address = node_addr;
					r.write_data = node_addr + offset;
					if (next_field != '0) begin
						node_addr = node_addr + next_field;
						r.read_enable = 1'b1;
						r.read_address = node_addr;
					end else begin
						r.chain_done = 1'b1;
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_word(logic [1:0] c, logic [31:0] w);
			pending_results.push_back(relocate_word(c, w));
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		function void match_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
				failures++;
			end
		endfunction

		function void check_result(reloc_result_t got);
			reloc_result_t exp;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, got);
				failures++;
				return;
			end
			exp = pending_results.pop_front();
			results_checked++;
			if (exp.chain_done)
				chains_ended++;
			if (exp.table_done)
				tables_ended++;
			if (exp.error != ERR_NONE)
				flagged++;
			match_field("write_enable", 32'(exp.write_enable), 32'(got.write_enable));
			match_field("write_address", exp.write_address, got.write_address);
			match_field("write_data", exp.write_data, got.write_data);
			match_field("read_enable", 32'(exp.read_enable), 32'(got.read_enable));
			match_field("read_address", exp.read_address, got.read_address);
			match_field("chain_done", 32'(exp.chain_done), 32'(got.chain_done));
			match_field("table_done", 32'(exp.table_done), 32'(got.table_done));
			match_field("error", 32'(exp.error), 32'(got.error));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [31:0]        word;
	logic               out_valid;
	logic               out_ready;
	logic               write_enable;
	logic [31:0]        write_address;
	logic [31:0]        write_data;
	logic               read_enable;
	logic [31:0]        read_address;
	logic               chain_done;
	logic               table_done;
	logic [1:0]         error;

	reloc_scoreboard sb;
	int              words_sent;
	int              settings_used;
	bit              steady_phase;   // no random idling on either side while set
	bit              hold_off_req;   // ask the receiver for one long stall

	pointer_chain_relocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.word          (word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.read_enable   (read_enable),
		.read_address  (read_address),
		.chain_done    (chain_done),
		.table_done    (table_done),
		.error         (error)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Check every result word taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({write_enable, write_address, write_data, read_enable,
				read_address, chain_done, table_done, error});
	end

	// Receiver: idle at random, never during a steady phase, and hold off for a long
	// stretch when asked so the block fills up and drops in_ready.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Offer one word, starting at a falling edge; return at the falling edge after it
	// is taken. Drop valid only for an idle gap, never in the step it is raised.
	task automatic push_word(logic [1:0] c, logic [31:0] w);
		if (!steady_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(c, w);
		words_sent++;
		@(negedge clk);
	endtask

	// Hold the input until every expected result has come back, then let the pipe settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Setup and access phase, then release the bus and let it idle before returning.
	task automatic write_register(logic [PADDR_W-1:0] a, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_register(a, d);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// New setting: only once the block has gone idle.
	task automatic configure(logic [31:0] base, logic [23:0] entries);
		drain();
		write_register(REG_ADDR_BASE, base);
		write_register(REG_ADDR_TABLE, {8'h00, entries});
		settings_used++;
	endtask

	// One table: a header, then chain starts each followed by a walk of node words.
	// Most chains are well formed; a few are cut short and some noise words slip in.
	task automatic run_table(int starts);
		logic [31:0] hdr;
		logic [31:0] link;
		logic [31:0] offs;
		int          width;
		int          k;
		int          hops;
		case ($urandom_range(0, 9))
			0:       hdr = $urandom;
			1:       hdr = 32'd0;
			default: hdr = $urandom_range(1, 30);
		endcase
		push_word(CMD_HEADER, hdr);
		width = (hdr > WIDTH_CLAMP) ? 30 : int'(hdr);
		k = 31 - width;
		repeat (starts) begin
			if ($urandom_range(0, 99) < 8)
				push_word(2'($urandom_range(0, 3)), $urandom);
			if ($urandom_range(0, 99) < 85)
				push_word(CMD_START, $urandom_range(0, 32'h04FF_FFFF));
			else
				push_word(CMD_START, $urandom);
			hops = (width == 0) ? 0 : $urandom_range(0, 5);
			repeat (hops) begin
				// nonzero next field in bits 30..k, random signed offset below it
				link = $urandom_range(1, (1 << width) - 1);
				offs = $urandom & ((32'd1 << k) - 32'd1);
				push_word(CMD_NODE, {1'b0, 31'((link << k) | offs)});
			end
			// close the chain: offset-only form or a plain node with next zero
			case ($urandom_range(0, 9))
				0:       ;
				1, 2, 3: push_word(CMD_NODE, {1'b1, 31'($urandom)});
				default: push_word(CMD_NODE, {1'b0, 31'($urandom & ((32'd1 << k) - 32'd1))});
			endcase
		end
	endtask

	initial begin : stimulus
		int phase;
		int starts;
		sb = new();
		words_sent = 0;
		settings_used = 0;
		steady_phase = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = CMD_HEADER;
		word = '0;
		out_ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a start and a node before any header, on reset registers.
		push_word(CMD_START, 32'd0);
		push_word(CMD_NODE, 32'd0);
		configure(32'h8000_0000, 24'd3);
		// Header widths: clamp, last clean width, first flagged, top of range.
		push_word(CMD_HEADER, 32'hFFFF_FFFF);
		push_word(CMD_HEADER, 32'd19);
		push_word(CMD_HEADER, 32'd20);
		push_word(CMD_HEADER, 32'd30);
		// Widest next field: one offset bit, all-ones word, then smallest step.
		push_word(CMD_START, 32'h04FF_FFFF);
		push_word(CMD_NODE, 32'h7FFF_FFFF);
		push_word(CMD_NODE, 32'h0000_0002);
		push_word(CMD_NODE, 32'h8000_0005);
		// First flagged offset, which also ends the table.
		push_word(CMD_START, 32'h0500_0000);
		push_word(CMD_NODE, 32'hC000_0010);
		// Address wrap past the top of memory, negative whole-word offset.
		push_word(CMD_START, 32'hFFFF_FFFF);
		push_word(CMD_NODE, 32'hFFFF_FFFF);
		push_word(CMD_UNUSED, 32'hFFFF_FFFF);
		push_word(CMD_UNUSED, 32'd0);
		// Narrowest nonzero next field, then zero width with a negative offset.
		push_word(CMD_HEADER, 32'd1);
		push_word(CMD_START, 32'd0);
		push_word(CMD_NODE, 32'h4000_0000);
		push_word(CMD_NODE, 32'h2000_0000);
		push_word(CMD_HEADER, 32'd0);
		push_word(CMD_NODE, 32'h7FFF_FFFF);

		// Random tables over many settings, extremes first.
		phase = 0;
		while (words_sent < WORD_TARGET) begin
			starts = $urandom_range(8, 20);
			case (phase)
				0:       configure(32'h0000_0000, 24'hFF_FFFF);
				1:       configure(32'hFFFF_FFFF, 24'd0);
				default: configure($urandom,
					(phase % 3 == 0) ? 24'(starts + 1) : 24'($urandom_range(0, 24'hFF_FFFF)));
			endcase
			steady_phase = (phase == 2 || phase == 3);
			if (phase == 3)
				hold_off_req = 1'b1;
			run_table(starts);
			phase++;
		end

		drain();
		steady_phase = 1'b0;
		$display("Covered %0d words across %0d register settings: %0d results checked,",
			words_sent, settings_used, sb.results_checked);
		$display("%0d chains closed, %0d tables completed, %0d flagged words.",
			sb.chains_ended, sb.tables_ended, sb.flagged);
		if (sb.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
